FILE: src/sha1_message_digest_core_macros.svh
// Assertion macros for the SHA-1 message digest core checker.
// Depends on nothing. Each macro expects signals named clk and rst_n in scope.
`ifndef SHA1_MESSAGE_DIGEST_CORE_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA1MD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha1md assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SHA1MD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha1md assertion failed");

`endif

FILE: src/sha1md_pkg.sv
// Shared types and constants for the SHA-1 message digest core.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package sha1md_pkg;

  localparam int COUNT_W   = 61;
  localparam int WIN_DEPTH = 16;
  localparam int NUM_WORDS = 5;
  localparam int ROUND_W   = 7;
  localparam int IDX_W     = 3;
  localparam int FILL_W    = 6;

  localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
  localparam logic [IDX_W-1:0]   LAST_IDX   = 3'd4;
  localparam logic [FILL_W-1:0]  FILL_LAST  = 6'd63;
  localparam logic [FILL_W-1:0]  FILL_LEN   = 6'd56;
  localparam logic [7:0]         PAD_BYTE   = 8'h80;

  // Round constants, one per group of twenty rounds.
  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  // Initial chaining values.
  localparam logic [31:0] H_INIT [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZERO,
    ST_PADLEN,
    ST_COMPRESS,
    ST_ADD,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_PAD80,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 shift_en;
    byte_sel_t            byte_sel;
    logic                 count_en;
    logic                 load_work;
    logic                 round_en;
    logic [ROUND_W-1:0]   round;
    logic                 add_en;
    logic                 init_en;
    logic [IDX_W-1:0]     word_idx;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_last;
    logic fill_at_len;
  } dp_sts_t;

endpackage

FILE: src/sha1md_ctrl.sv
// Controller state machine for the SHA-1 message digest core.
// Depends on sha1md_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps

module sha1md_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_has_byte,
  input  logic                    in_end_of_message,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              out_word_index,
  output logic                    out_final_word,
  input  sha1md_pkg::dp_sts_t     sts,
  output sha1md_pkg::dp_cmd_t     cmd
);
  import sha1md_pkg::*;

  ctrl_state_t        state_r, state_nxt;
  ctrl_state_t        ret_r, ret_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      round_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      round_r <= round_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Next state, return target and counters.
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    round_nxt = round_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_has_byte && sts.fill_last) begin
            state_nxt = ST_COMPRESS;
            ret_nxt   = in_end_of_message ? ST_PAD80 : ST_IDLE;
            round_nxt = '0;
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD80;
          end
        end
      end
      ST_PAD80: begin
        if (sts.fill_last) begin
          state_nxt = ST_COMPRESS;
          ret_nxt   = ST_PADZERO;
          round_nxt = '0;
        end else begin
          state_nxt = ST_PADZERO;
        end
      end
      ST_PADZERO: begin
        if (sts.fill_at_len) begin
          state_nxt = ST_PADLEN;
        end else if (sts.fill_last) begin
          state_nxt = ST_COMPRESS;
          ret_nxt   = ST_PADZERO;
          round_nxt = '0;
        end
      end
      ST_PADLEN: begin
        if (sts.fill_last) begin
          state_nxt = ST_COMPRESS;
          ret_nxt   = ST_EMIT;
          round_nxt = '0;
          idx_nxt   = '0;
        end
      end
      ST_COMPRESS: begin
        round_nxt = round_r + 7'd1;
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        state_nxt = ret_r;
      end
      ST_EMIT: begin
        if (!out_stall) begin
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath commands and handshake outputs.
  always_comb begin
    cmd           = '0;
    cmd.byte_sel  = SEL_MSG;
    cmd.round     = round_r;
    cmd.word_idx  = idx_r;
    in_stall      = (state_r != ST_IDLE);
    out_valid     = (state_r == ST_EMIT);
    out_word_index = idx_r;
    out_final_word = (idx_r == LAST_IDX);
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_has_byte) begin
          cmd.shift_en  = 1'b1;
          cmd.count_en  = 1'b1;
          cmd.load_work = sts.fill_last;
        end
      end
      ST_PAD80: begin
        cmd.shift_en  = 1'b1;
        cmd.byte_sel  = SEL_PAD80;
        cmd.load_work = sts.fill_last;
      end
      ST_PADZERO: begin
        if (!sts.fill_at_len) begin
          cmd.shift_en  = 1'b1;
          cmd.byte_sel  = SEL_ZERO;
          cmd.load_work = sts.fill_last;
        end
      end
      ST_PADLEN: begin
        cmd.shift_en  = 1'b1;
        cmd.byte_sel  = SEL_LEN;
        cmd.load_work = sts.fill_last;
      end
      ST_COMPRESS: begin
        cmd.round_en = 1'b1;
      end
      ST_ADD: begin
        cmd.add_en = 1'b1;
      end
      ST_EMIT: begin
        cmd.init_en = !out_stall && (idx_r == LAST_IDX);
      end
      default: begin
        cmd.shift_en = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/sha1md_dp.sv
// Datapath for the SHA-1 message digest core: block buffer and schedule
// window, working registers, chaining words and counters. Depends on sha1md_pkg.
`timescale 1ns / 1ps

module sha1md_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            in_data_byte,
  input  sha1md_pkg::dp_cmd_t   cmd,
  output sha1md_pkg::dp_sts_t   sts,
  output logic [31:0]           out_digest_word
);
  import sha1md_pkg::*;

  // The window holds the block bytes while filling and the message
  // schedule during the rounds; word 0 is always the next word to use.
  logic [31:0]        win_r [WIN_DEPTH];
  logic [31:0]        h_r [NUM_WORDS];
  logic [31:0]        a_r, b_r, c_r, d_r, e_r;
  logic [COUNT_W-1:0] count_r;
  logic [FILL_W-1:0]  fill_r;

  logic [7:0]  byte_in;
  logic [63:0] len_bits;
  logic [31:0] w_new;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;

  assign sts.fill_last   = (fill_r == FILL_LAST);
  assign sts.fill_at_len = (fill_r == FILL_LEN);
  assign out_digest_word = h_r[cmd.word_idx];

  // Length bytes go out most significant first, indexed by the fill position.
  assign len_bits = {count_r, 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      SEL_MSG:   byte_in = in_data_byte;
      SEL_PAD80: byte_in = PAD_BYTE;
      SEL_ZERO:  byte_in = 8'h00;
      SEL_LEN:   byte_in = 8'(len_bits >> {~fill_r[2:0], 3'b000});
      default:   byte_in = 8'h00;
    endcase
  end

  // Round function and schedule expansion.
  assign w_new = {win_r[13][30:0] ^ win_r[8][30:0] ^ win_r[2][30:0] ^ win_r[0][30:0],
                  win_r[13][31] ^ win_r[8][31] ^ win_r[2][31] ^ win_r[0][31]};

  always_comb begin
    if (cmd.round < 7'd20) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = K_0;
    end else if (cmd.round < 7'd40) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_1;
    end else if (cmd.round < 7'd60) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = K_2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_3;
    end
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + win_r[0];

  // Window: byte shift while filling, word shift during the rounds.
  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_r[i] <= {win_r[i][23:0], win_r[i+1][31:24]};
      end
      win_r[WIN_DEPTH-1] <= {win_r[WIN_DEPTH-1][23:0], byte_in};
    end else if (cmd.round_en) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WIN_DEPTH-1] <= w_new;
    end
  end

  // Working registers: loaded from the chaining words, one round per cycle.
  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (cmd.round_en) begin
      a_r <= t_val;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  // Chaining words, byte count and fill position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        h_r[i] <= H_INIT[i];
      end
      count_r <= '0;
      fill_r  <= '0;
    end else begin
      if (cmd.init_en) begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          h_r[i] <= H_INIT[i];
        end
        count_r <= '0;
      end else begin
        if (cmd.add_en) begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
        end
        if (cmd.count_en) begin
          count_r <= count_r + 61'd1;
        end
      end
      if (cmd.shift_en) begin
        fill_r <= fill_r + 6'd1;
      end
    end
  end

endmodule

FILE: src/sha1_message_digest_core.sv
// SHA-1 message digest core: one byte per input transaction, five digest words out.
// Input bytes are taken while idle; each full 64-byte block then runs 80 rounds and
// one add, all in the shared round unit, with the input stalled. Padding bytes are
// shifted in by the controller, and the digest is five output transactions.
// Reset (rst_n, synchronous, active low) loads the initial chaining values and
// clears the byte count; the block then accepts input at once.
`timescale 1ns / 1ps

module sha1_message_digest_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_final_word
);
  import sha1md_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Controller: sequences byte intake, padding, rounds and digest output.
  sha1md_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_word_index    (out_word_index),
    .out_final_word    (out_final_word),
    .sts               (sts),
    .cmd               (cmd)
  );

  // Datapath: buffer, schedule, rounds and chaining words.
  sha1md_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_digest_word (out_digest_word)
  );

endmodule

FILE: src/sha1md_checker.sv
// Port-level checker for the SHA-1 message digest core, bound to the top level.
// Depends on sha1_message_digest_core_macros.svh.
`timescale 1ns / 1ps
`include "sha1_message_digest_core_macros.svh"

module sha1md_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_final_word
);

  // No input is taken while the digest is being delivered.
  `SHA1MD_ASSERT_SAME(a_busy_during_emit, out_valid, in_stall)

  // The last word carries the final flag and only it does.
  `SHA1MD_ASSERT_SAME(a_final_flag, out_valid, out_final_word == (out_word_index == 3'd4))

  // An accepted non-final word is followed by the next word.
  `SHA1MD_ASSERT_NEXT(a_index_step, out_valid && !out_stall && !out_final_word, out_valid && (out_word_index == $past(out_word_index) + 3'd1))

  // After the final word the block is ready for a new message.
  `SHA1MD_ASSERT_NEXT(a_ready_after_digest, out_valid && !out_stall && out_final_word, !out_valid && !in_stall)

  // A stalled word holds.
  `SHA1MD_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_digest_word))

endmodule

bind sha1_message_digest_core sha1md_checker u_sha1md_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_digest_word (out_digest_word),
  .out_word_index  (out_word_index),
  .out_final_word  (out_final_word)
);

FILE: test/sha1_message_digest_core_tb.sv
// Self-checking testbench for the SHA-1 message digest core.
// Depends on sha1md_pkg and sha1_message_digest_core; a scoreboard class predicts the digests.
`timescale 1ns / 1ps

module sha1_message_digest_core_tb;
  import sha1md_pkg::*;

  // Expected digest words, predicted from every accepted input transaction.
  class sha1_digest_scoreboard;
    typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        tail;
    } digest_entry_t;

    bit [31:0]     chain [NUM_WORDS];
    bit [7:0]      block_bytes [64];
    bit [60:0]     byte_count;
    digest_entry_t digest_q [$];
    int unsigned   error_count;
    int unsigned   words_checked;
    int unsigned   messages_closed;

    function new();
      foreach (block_bytes[i]) block_bytes[i] = 8'h00;
      error_count = 0;
      words_checked = 0;
      messages_closed = 0;
      restart_message();
    endfunction

    function void restart_message();
      foreach (chain[i]) chain[i] = H_INIT[i];
      byte_count = '0;
    endfunction

    function bit [31:0] rotl(bit [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    // One 80-round compression of the buffered block into the chaining words.
    function void compress_block();
      bit [31:0] w [16];
      bit [31:0] a, b, c, d, e, f, k, t;
      int        r;
      for (r = 0; r < 16; r++) begin
        w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (r = 0; r < 80; r++) begin
        if (r >= 16) begin
          w[r%16] = rotl(w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16], 1);
        end
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = K_0;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = K_1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K_2;
        end else begin
          f = b ^ c ^ d;
          k = K_3;
        end
        t = rotl(a, 5) + f + e + k + w[r%16];
        e = d;
        d = c;
        c = rotl(b, 30);
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    // Account for one accepted input transaction.
    function void note_item(bit [7:0] data, bit has, bit last);
      int        pos;
      bit [63:0] bit_len;
      digest_entry_t entry;
      if (has) begin
        block_bytes[byte_count[5:0]] = data;
        byte_count = byte_count + 1'b1;
        if (byte_count[5:0] == 6'd0) compress_block();
      end
      if (!last) return;
      // Standard padding, with a second block when the length field does not fit.
      pos = byte_count[5:0];
      bit_len = {byte_count, 3'b000};
      block_bytes[pos] = PAD_BYTE;
      for (int i = pos + 1; i < 64; i++) block_bytes[i] = 8'h00;
      if (pos > 55) begin
        compress_block();
        for (int i = 0; i < 56; i++) block_bytes[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) block_bytes[63-i] = bit_len[8*i +: 8];
      compress_block();
      for (int i = 0; i < NUM_WORDS; i++) begin
        entry.word = chain[i];
        entry.index = i[2:0];
        entry.tail = (i == NUM_WORDS - 1);
        digest_q.push_back(entry);
      end
      messages_closed++;
      restart_message();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
    endtask

    // Compare one accepted result transaction with the oldest expected word.
    task check_word(logic [31:0] word, logic [2:0] index, logic tail);
      digest_entry_t entry;
      if (digest_q.size() == 0) begin
        report_mismatch($sformatf("digest word %h with no word expected", word));
        return;
      end
      entry = digest_q.pop_front();
      words_checked++;
      if (word !== entry.word)
        report_mismatch($sformatf("digest_word got %h exp %h", word, entry.word));
      if (index !== entry.index)
        report_mismatch($sformatf("word_index got %0d exp %0d", index, entry.index));
      if (tail !== entry.tail)
        report_mismatch($sformatf("final_word got %b exp %b", tail, entry.tail));
    endtask
  endclass

  localparam int NUM_STIM_ITEMS = 430;
  localparam int QUIET_FROM     = 370;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 400;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_has_byte;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_final_word;

  sha1_digest_scoreboard digest_sb = new();

  int unsigned stim_items = 0;
  int unsigned longest_msg = 0;
  bit          quiet_phase = 1'b0;
  bit          hold_off_request = 1'b0;

  sha1_message_digest_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_final_word    (out_final_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Both channel monitors sample the pre-edge values at each rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      digest_sb.note_item(in_data_byte, in_has_byte, in_end_of_message);
    if (rst_n && out_valid && !out_stall)
      digest_sb.check_word(out_digest_word, out_word_index, out_final_word);
  end

  // Offer one input transaction and wait until the block takes it.
  task automatic send_item(bit [7:0] data, bit has, bit last);
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_has_byte <= has;
    in_end_of_message <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (has || last) stim_items++;
  endtask

  // Drop valid for a random burst now and then, except in the quiet phase.
  task automatic idle_gap();
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Send a whole message; fill selects random, all-zero or all-one bytes.
  task automatic send_message(int unsigned len, bit end_only, int unsigned fill);
    bit [7:0] b;
    if (len > longest_msg) longest_msg = len;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        idle_gap();
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      case (fill)
        0: b = 8'($urandom_range(0, 255));
        1: b = 8'h00;
        default: b = 8'hFF;
      endcase
      idle_gap();
      send_item(b, 1'b1, !end_only && (i == len - 1));
    end
    if (end_only || len == 0) begin
      idle_gap();
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  // The receiver stalls in random bursts, or once for a long hold-off on request.
  initial begin : receiver
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_request = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (quiet_phase || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Main sequence: reset, directed messages, a long hold-off, then random messages.
  initial begin : stimulus
    int unsigned boundary_len [10];
    int unsigned sel;
    int unsigned len;
    boundary_len = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data_byte <= 8'h00;
    in_has_byte <= 1'b0;
    in_end_of_message <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message, a transaction that does nothing, and an end marker with a stray byte.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    // Single extreme bytes that close the message themselves.
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    // The classic three-byte message.
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // A byte followed by an end-only marker whose data must be ignored.
    send_item(8'h7E, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    // An ignored transaction in the middle of a message.
    send_item(8'h5A, 1'b1, 1'b0);
    send_item(8'hC3, 1'b0, 1'b0);
    send_item(8'h01, 1'b1, 1'b1);

    // Hold the receiver off while several short messages keep arriving.
    hold_off_request = 1'b1;
    repeat (3) send_message($urandom_range(1, 4), 1'b0, 0);

    // Random messages, most of them short, many at the padding boundaries.
    while (stim_items < NUM_STIM_ITEMS) begin
      if (stim_items >= QUIET_FROM) quiet_phase = 1'b1;
      sel = $urandom_range(0, 9);
      if (sel < 5) len = $urandom_range(0, 8);
      else if (sel < 8) len = boundary_len[$urandom_range(0, 9)];
      else len = $urandom_range(9, 140);
      sel = $urandom_range(0, 9);
      send_message(len, $urandom_range(0, 3) == 0, (sel < 8) ? 0 : sel - 7);
    end
    in_valid <= 1'b0;

    while (digest_sb.digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d messages in %0d input transactions, longest %0d bytes;",
             digest_sb.messages_closed, stim_items, longest_msg);
    $display("checked %0d digest words with %0d mismatches",
             digest_sb.words_checked, digest_sb.error_count);
    if (digest_sb.error_count == 0) begin
      $display("sha1_message_digest_core_tb: clean");
    end else begin
      $display("sha1_message_digest_core_tb: errors");
    end
    $finish;
  end

  // Safety net for a hung handshake or missing digest words.
  initial begin : watchdog
    #20ms;
    $display("timeout with %0d digest words still expected", digest_sb.digest_q.size());
    $display("sha1_message_digest_core_tb: errors");
    $finish;
  end

endmodule

FILE: sha1_message_digest_core.f
+incdir+src
src/sha1md_pkg.sv
src/sha1md_ctrl.sv
src/sha1md_dp.sv
src/sha1_message_digest_core.sv
src/sha1md_checker.sv
test/sha1_message_digest_core_tb.sv
